// ===== src/eap_tls_fragment_reassembly_check_unit_assert.svh =====
// assertion macros shared by the eap-tls reassembly check rtl
// expects i_clk and i_rst_n in the scope of every use
`ifndef EAP_TLS_FRAGMENT_REASSEMBLY_CHECK_UNIT_ASSERT_SVH
`define EAP_TLS_FRAGMENT_REASSEMBLY_CHECK_UNIT_ASSERT_SVH

// same-cycle implication
`define EAPTLS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EAPTLS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/eaptls_pkg.sv =====
// types and constants for the eap-tls fragment reassembly check
// no dependencies
`default_nettype none

package eaptls_pkg;

    localparam int EAP_HDR_BYTES = 4;

    // header with and without the four-byte tls length field
    localparam logic [15:0] HDR_L_BYTES    = 16'(EAP_HDR_BYTES + 6);
    localparam logic [15:0] HDR_NO_L_BYTES = 16'(EAP_HDR_BYTES + 2);

    localparam logic [7:0]  FLAG_LM   = 8'hc0;
    localparam int          FLAG_L_BIT = 7;
    localparam int          FLAG_M_BIT = 6;
    localparam int          FLAG_S_BIT = 5;

    localparam logic [15:0] MAX_RECORD_RESET = 16'd16384;
    localparam logic [16:0] RECV_MAX         = 17'h1ffff;

    localparam logic [2:0] OFFSET_L    = 3'd5;
    localparam logic [2:0] OFFSET_NO_L = 3'd1;

    localparam logic [2:0] ST_INVALID  = 3'd0;
    localparam logic [2:0] ST_ACK      = 3'd1;
    localparam logic [2:0] ST_FIRST    = 3'd2;
    localparam logic [2:0] ST_MORE     = 3'd3;
    localparam logic [2:0] ST_COMPLETE = 3'd4;

    // classification made before the reassembly state is consulted
    typedef enum logic [2:0] {
        K_INVALID,
        K_ACK,
        K_L_FIRST,
        K_L_ONLY,
        K_MORE,
        K_FINAL
    } t_kind;

    typedef struct packed {
        logic [15:0] eap_length;
        logic [7:0]  flags;
        logic [15:0] message_length;
        logic        ack_id_ok;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] fragment_length;
        logic [2:0]  payload_offset;
    } t_out_item;

    typedef struct packed {
        t_kind       kind;
        logic        l_match;
        logic [15:0] total;
        logic [15:0] frag;
        logic [2:0]  offset;
    } t_cls_item;

endpackage

`default_nettype wire

// ===== src/eaptls_front.sv =====
// front end: holds max_record_len and classifies each incoming item
// depends on eaptls_pkg
`default_nettype none

module eaptls_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [15:0]          i_cfg_wdata,
    input  wire eaptls_pkg::t_in_item i_item,
    output eaptls_pkg::t_cls_item     o_cls
);

    logic [15:0] r_max_record_len;
    logic        has_l;
    logic        has_m;
    logic [15:0] hdr;
    logic        short_pkt;
    logic [15:0] frag;
    eaptls_pkg::t_kind kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_record_len <= eaptls_pkg::MAX_RECORD_RESET;
        end else if (i_cfg_we) begin
            r_max_record_len <= i_cfg_wdata;
        end
    end

    assign has_l     = i_item.flags[eaptls_pkg::FLAG_L_BIT];
    assign has_m     = i_item.flags[eaptls_pkg::FLAG_M_BIT];
    assign hdr       = has_l ? eaptls_pkg::HDR_L_BYTES : eaptls_pkg::HDR_NO_L_BYTES;
    assign short_pkt = i_item.eap_length < hdr;
    assign frag      = short_pkt ? 16'd0 : (i_item.eap_length - hdr);

    always_comb begin
        if (short_pkt) begin
            kind = eaptls_pkg::K_INVALID;
        end else if (i_item.eap_length == eaptls_pkg::HDR_NO_L_BYTES &&
                     (i_item.flags & eaptls_pkg::FLAG_LM) == 8'd0) begin
            kind = i_item.ack_id_ok ? eaptls_pkg::K_ACK : eaptls_pkg::K_INVALID;
        end else if (i_item.flags[eaptls_pkg::FLAG_S_BIT]) begin
            // start from the peer is refused
            kind = eaptls_pkg::K_INVALID;
        end else if (has_l) begin
            if (frag > i_item.message_length || i_item.message_length > r_max_record_len) begin
                kind = eaptls_pkg::K_INVALID;
            end else begin
                kind = has_m ? eaptls_pkg::K_L_FIRST : eaptls_pkg::K_L_ONLY;
            end
        end else begin
            kind = has_m ? eaptls_pkg::K_MORE : eaptls_pkg::K_FINAL;
        end
    end

    always_comb begin
        o_cls.kind    = kind;
        o_cls.l_match = (i_item.message_length == frag);
        o_cls.total   = i_item.message_length;
        o_cls.frag    = frag;
        o_cls.offset  = has_l ? eaptls_pkg::OFFSET_L : eaptls_pkg::OFFSET_NO_L;
    end

endmodule

`default_nettype wire

// ===== src/eaptls_queue.sv =====
// two-entry queue between the classifier and the reassembly tracker
// depends on eaptls_pkg
`default_nettype none

module eaptls_queue (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire eaptls_pkg::t_cls_item i_data,
    output logic                       o_full,
    input  wire logic                  i_pop,
    output logic                       o_valid,
    output eaptls_pkg::t_cls_item      o_data
);

    eaptls_pkg::t_cls_item r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

`default_nettype wire

// ===== src/eaptls_back.sv =====
// back end: reassembly state tracking and the result register
// depends on eaptls_pkg and the assertion macro header
`default_nettype none
`include "eap_tls_fragment_reassembly_check_unit_assert.svh"

module eaptls_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire eaptls_pkg::t_cls_item i_cls,
    output logic                       o_ready,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output eaptls_pkg::t_out_item      o_out_item
);

    logic        r_active;
    logic [15:0] r_expected;
    logic [16:0] r_received;
    logic        r_out_valid;
    eaptls_pkg::t_out_item r_out;

    logic        n_active;
    logic [15:0] n_expected;
    logic [16:0] n_received;
    logic [2:0]  n_status;

    logic        load;
    logic [17:0] sum;
    logic [16:0] sat;

    assign o_ready     = !r_out_valid || i_out_ready;
    assign load        = i_valid && o_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // received count saturates instead of wrapping
    assign sum = {1'b0, r_received} + {2'b00, i_cls.frag};
    assign sat = sum[17] ? eaptls_pkg::RECV_MAX : sum[16:0];

    always_comb begin
        n_active   = r_active;
        n_expected = r_expected;
        n_received = r_received;
        n_status   = eaptls_pkg::ST_INVALID;
        case (i_cls.kind)
            eaptls_pkg::K_INVALID: begin
                n_status = eaptls_pkg::ST_INVALID;
            end
            eaptls_pkg::K_ACK: begin
                n_status = eaptls_pkg::ST_ACK;
            end
            eaptls_pkg::K_L_FIRST, eaptls_pkg::K_MORE: begin
                if (!r_active && i_cls.kind == eaptls_pkg::K_L_FIRST) begin
                    n_expected = i_cls.total;
                    n_received = {1'b0, i_cls.frag};
                    n_active   = 1'b1;
                    n_status   = eaptls_pkg::ST_FIRST;
                end else if (!r_active) begin
                    n_status = eaptls_pkg::ST_INVALID;
                end else begin
                    // l during a transfer is ignored
                    n_received = sat;
                    n_status   = (sat > {1'b0, r_expected}) ? eaptls_pkg::ST_INVALID
                                                            : eaptls_pkg::ST_MORE;
                end
            end
            eaptls_pkg::K_L_ONLY, eaptls_pkg::K_FINAL: begin
                if (r_active) begin
                    n_active   = 1'b0;
                    n_received = sat;
                    n_status   = (sat != {1'b0, r_expected}) ? eaptls_pkg::ST_INVALID
                                                             : eaptls_pkg::ST_COMPLETE;
                end else if (i_cls.kind == eaptls_pkg::K_L_ONLY) begin
                    n_status = i_cls.l_match ? eaptls_pkg::ST_COMPLETE
                                             : eaptls_pkg::ST_INVALID;
                end else begin
                    n_status = eaptls_pkg::ST_COMPLETE;
                end
            end
            default: begin
                n_status = eaptls_pkg::ST_INVALID;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_expected  <= 16'd0;
            r_received  <= 17'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_active   <= n_active;
                r_expected <= n_expected;
                r_received <= n_received;
                r_out.status          <= n_status;
                r_out.fragment_length <= i_cls.frag;
                r_out.payload_offset  <= i_cls.offset;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `EAPTLS_ASSERT_NXT(a_first_opens, load && n_status == eaptls_pkg::ST_FIRST, r_active, "first fragment did not open a transfer")
    `EAPTLS_ASSERT_NXT(a_final_closes, load && r_active && i_cls.kind == eaptls_pkg::K_FINAL, !r_active, "final fragment left transfer open")
    `EAPTLS_ASSERT_IMP(a_ack_only_kind, load && i_cls.kind != eaptls_pkg::K_ACK, n_status != eaptls_pkg::ST_ACK, "ack status without ack item")

endmodule

`default_nettype wire

// ===== src/eap_tls_fragment_reassembly_check_unit.sv =====
// eap-tls response fragment check: top level
// depends on eaptls_pkg, eaptls_front, eaptls_queue, eaptls_back
//
// Input channel (i_in_valid / o_in_ready, i_in_item) carries one received
// EAP-TLS response descriptor per item; output channel (o_out_valid /
// i_out_ready, o_out_item) returns exactly one result per item, in order.
// i_cfg_we / i_cfg_wdata write max_record_len; write it
// only while no item is in flight.
// The front classifies the item in the accept cycle and pushes it into a
// two-entry queue; the back pops one entry per cycle while its result
// register is free or being taken, updates the reassembly counters and
// loads the result register.
// Each item is held in a queue entry before the back end loads its result.
// Throughput: one item per cycle while the receiver keeps taking results;
// the back end updates its transfer state once per item.
// Reset (synchronous, active low) clears the transfer state, empties the
// queue and result register, and sets max_record_len to 16384.
// When the receiver stalls the result is held, the queue fills, and
// o_in_ready drops once both queue entries are taken.
`default_nettype none

module eap_tls_fragment_reassembly_check_unit (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [15:0]          i_cfg_wdata,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire eaptls_pkg::t_in_item i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output eaptls_pkg::t_out_item     o_out_item
);

    eaptls_pkg::t_cls_item cls;
    eaptls_pkg::t_cls_item q_data;
    logic q_full;
    logic q_valid;
    logic back_ready;

    assign o_in_ready = !q_full;

    eaptls_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (i_in_item),
        .o_cls       (cls)
    );

    eaptls_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_data  (cls),
        .o_full  (q_full),
        .i_pop   (back_ready),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    eaptls_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_cls       (q_data),
        .o_ready     (back_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

// ===== dv/eaptls_response_checker.sv =====
// response checker for the eap-tls fragment reassembly check unit
// predicts one response per accepted item and compares in order; needs eaptls_pkg
module eaptls_response_checker (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [15:0]          i_cfg_wdata,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_ready,
    input  eaptls_pkg::t_in_item      i_in_item,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_ready,
    input  eaptls_pkg::t_out_item     i_out_item,
    output int                        o_fail_count,
    output int                        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic        xfer_active    = 1'b0;
    logic [15:0] record_total   = '0;
    logic [16:0] bytes_received = '0;
    logic [15:0] max_record_len = eaptls_pkg::MAX_RECORD_RESET;
    eaptls_pkg::t_out_item expected_responses[$];
    int          fails = 0;

    function automatic logic [16:0] add_saturated(logic [16:0] acc, logic [15:0] n);
        logic [17:0] s;
        s = {1'b0, acc} + {2'b00, n};
        return (s > {1'b0, eaptls_pkg::RECV_MAX}) ? eaptls_pkg::RECV_MAX : s[16:0];
    endfunction

    function automatic eaptls_pkg::t_out_item predict_response(eaptls_pkg::t_in_item req);
        logic        has_l;
        logic        has_m;
        logic [15:0] hdr;
        logic [15:0] frag;
        eaptls_pkg::t_out_item rsp;
        has_l = req.flags[eaptls_pkg::FLAG_L_BIT];
        has_m = req.flags[eaptls_pkg::FLAG_M_BIT];
        hdr   = has_l ? eaptls_pkg::HDR_L_BYTES : eaptls_pkg::HDR_NO_L_BYTES;
        frag  = (req.eap_length >= hdr) ? req.eap_length - hdr : 16'd0;
        rsp.fragment_length = frag;
        rsp.payload_offset  = has_l ? eaptls_pkg::OFFSET_L : eaptls_pkg::OFFSET_NO_L;
        // header with l is never shorter than without, so one compare covers both
        if (req.eap_length < hdr) begin
            rsp.status = eaptls_pkg::ST_INVALID;
        end else if (req.eap_length == eaptls_pkg::HDR_NO_L_BYTES
                     && (req.flags & eaptls_pkg::FLAG_LM) == 8'h00) begin
            rsp.status = req.ack_id_ok ? eaptls_pkg::ST_ACK : eaptls_pkg::ST_INVALID;
        end else if (req.flags[eaptls_pkg::FLAG_S_BIT]) begin
            rsp.status = eaptls_pkg::ST_INVALID;
        end else if (has_l && (frag > req.message_length
                               || req.message_length > max_record_len)) begin
            rsp.status = eaptls_pkg::ST_INVALID;
        end else if (has_l && !xfer_active) begin
            if (has_m) begin
                record_total   = req.message_length;
                bytes_received = {1'b0, frag};
                xfer_active    = 1'b1;
                rsp.status     = eaptls_pkg::ST_FIRST;
            end else begin
                rsp.status = (req.message_length == frag) ? eaptls_pkg::ST_COMPLETE
                                                          : eaptls_pkg::ST_INVALID;
            end
        end else if (has_m) begin
            // l during a transfer lands here as a plain fragment
            if (!xfer_active) begin
                rsp.status = eaptls_pkg::ST_INVALID;
            end else begin
                bytes_received = add_saturated(bytes_received, frag);
                rsp.status = (bytes_received > {1'b0, record_total})
                             ? eaptls_pkg::ST_INVALID : eaptls_pkg::ST_MORE;
            end
        end else if (xfer_active) begin
            xfer_active    = 1'b0;
            bytes_received = add_saturated(bytes_received, frag);
            rsp.status = (bytes_received != {1'b0, record_total})
                         ? eaptls_pkg::ST_INVALID : eaptls_pkg::ST_COMPLETE;
        end else begin
            rsp.status = eaptls_pkg::ST_COMPLETE;
        end
        return rsp;
    endfunction

    always @(posedge i_clk) begin : watch
        eaptls_pkg::t_out_item want;
        if (!i_rst_n) begin
            xfer_active    = 1'b0;
            record_total   = '0;
            bytes_received = '0;
            max_record_len = eaptls_pkg::MAX_RECORD_RESET;
            expected_responses.delete();
        end else begin
            if (i_cfg_we) begin
                max_record_len = i_cfg_wdata;
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_responses.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("%0t unexpected response: status %0d frag %0d offset %0d",
                                 $realtime, i_out_item.status, i_out_item.fragment_length,
                                 i_out_item.payload_offset);
                    end
                end else begin
                    want = expected_responses.pop_front();
                    if (i_out_item.status !== want.status
                        || i_out_item.fragment_length !== want.fragment_length
                        || i_out_item.payload_offset !== want.payload_offset) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("%0t response mismatch: exp status %0d frag %0d offset %0d, got status %0d frag %0d offset %0d",
                                     $realtime, want.status, want.fragment_length,
                                     want.payload_offset, i_out_item.status,
                                     i_out_item.fragment_length, i_out_item.payload_offset);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_responses.push_back(predict_response(i_in_item));
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_responses.size();
    end

endmodule

// ===== dv/tb_eap_tls_fragment_reassembly_check_unit.sv =====
// top of the eap-tls fragment reassembly check testbench: clock, reset, stimulus, verdict
// depends on eaptls_pkg, the rtl top and eaptls_response_checker
module tb_eap_tls_fragment_reassembly_check_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] FL_L    = 8'h80;
    localparam logic [7:0] FL_M    = 8'h40;
    localparam logic [7:0] FL_S    = 8'h20;
    localparam logic [7:0] FL_RSVD = 8'h1f;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 600;
    localparam int PHASES       = 5;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        i_in_valid  = 1'b0;
    eaptls_pkg::t_in_item  i_in_item = '0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    eaptls_pkg::t_out_item o_out_item;

    int fail_count;
    int pending;
    int cycles     = 0;
    int items_sent = 0;
    int cur_max    = 16384;
    int send_burst = 0;

    eap_tls_fragment_reassembly_check_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    eaptls_response_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_item   (o_out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic push_item(eaptls_pkg::t_in_item it);
        int gap;
        if (send_burst > 0) begin
            gap = 0;
            send_burst--;
        end else begin
            gap = idle_len();
            if ($urandom_range(0, 29) == 0) send_burst = $urandom_range(20, 60);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    task automatic send_fields(logic [15:0] len, logic [7:0] fl, logic [15:0] msg,
                               logic id_ok);
        eaptls_pkg::t_in_item it;
        it.eap_length     = len;
        it.flags          = fl;
        it.message_length = msg;
        it.ack_id_ok      = id_ok;
        push_item(it);
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_max(logic [15:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_max = v;
    endtask

    task automatic send_ack();
        logic [7:0] fl;
        fl = ($urandom_range(0, 3) == 0) ? FL_S : 8'h00;
        fl |= 8'($urandom) & FL_RSVD;
        send_fields(eaptls_pkg::HDR_NO_L_BYTES, fl, 16'($urandom), 1'($urandom));
    endtask

    task automatic send_noise();
        logic [15:0] len;
        len = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 16)) : 16'($urandom);
        send_fields(len, 8'($urandom), 16'($urandom), 1'($urandom));
    endtask

    // unfragmented record, with or without the length field
    task automatic send_whole();
        int          f;
        logic [7:0]  fl;
        logic [15:0] msg;
        f  = $urandom_range(0, (cur_max < 400) ? cur_max : 400);
        fl = ($urandom_range(0, 3) == 0) ? 8'h00 : FL_L;
        msg = 16'(f);
        if ($urandom_range(0, 4) == 0) msg = 16'(f + $urandom_range(0, 2) - 1);
        if ($urandom_range(0, 3) == 0) fl |= 8'($urandom) & FL_RSVD;
        send_fields(16'(f) + (((fl & FL_L) != 0) ? eaptls_pkg::HDR_L_BYTES
                                                 : eaptls_pkg::HDR_NO_L_BYTES),
                    fl, msg, 1'($urandom));
    endtask

    // fragmented record: first with l and m, middles with m, last without m
    task automatic send_record();
        int          total;
        int          left;
        int          nfrag;
        int          f;
        bit          is_last;
        logic [7:0]  fl;
        logic [15:0] msg;
        total = ($urandom_range(0, 7) == 0) ? $urandom_range(0, cur_max)
                                            : $urandom_range(0, (cur_max < 400) ? cur_max : 400);
        if (cur_max < 65535 && $urandom_range(0, 15) == 0) total = cur_max + 1;
        nfrag = $urandom_range(2, 5);
        left  = total;
        for (int i = 0; i < nfrag; i++) begin
            is_last = (i == nfrag - 1);
            f = is_last ? left : $urandom_range(0, left);
            if (is_last && $urandom_range(0, 7) == 0) f += $urandom_range(1, 3);
            if (f > 65525) f = 65525;
            left -= f;
            if (i == 0) begin
                fl = FL_L | FL_M;
            end else if (!is_last) begin
                fl = ($urandom_range(0, 3) == 0) ? (FL_L | FL_M) : FL_M;
            end else begin
                fl = ($urandom_range(0, 7) == 0) ? FL_L : 8'h00;
            end
            if ($urandom_range(0, 3) == 0) fl |= 8'($urandom) & FL_RSVD;
            msg = ((fl & FL_L) != 0) ? 16'(total) : 16'($urandom);
            if ($urandom_range(0, 9) == 0) send_ack();
            // lose a middle fragment now and then
            if (i != 0 && !is_last && $urandom_range(0, 15) == 0) continue;
            send_fields(16'(f) + (((fl & FL_L) != 0) ? eaptls_pkg::HDR_L_BYTES
                                                     : eaptls_pkg::HDR_NO_L_BYTES),
                        fl, msg, 1'($urandom));
        end
    endtask

    initial begin : receiver
        int stall;
        int burst;
        burst = 0;
        @(posedge i_clk);
        forever begin
            if (burst > 0) begin
                i_out_ready <= 1'b1;
                burst--;
                @(posedge i_clk);
            end else begin
                stall = idle_len();
                if (stall > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
                if ($urandom_range(0, 24) == 0) burst = $urandom_range(20, 80);
            end
        end
    end

    initial begin : stimulus
        int phase_max[PHASES];
        int target;
        int pick;
        phase_max[0] = 65535;
        phase_max[1] = 0;
        phase_max[2] = 300;
        phase_max[3] = $urandom_range(1, 65534);
        phase_max[4] = 16384;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, record limit at its reset value
        send_fields(16'd0,     8'h00,       16'd0,     1'b1);   // too short
        send_fields(16'd9,     FL_L,        16'd0,     1'b1);   // too short for l header
        send_fields(16'd6,     8'h00,       16'd0,     1'b1);   // ack
        send_fields(16'd6,     8'h00,       16'd0,     1'b0);   // ack, id mismatch
        send_fields(16'd6,     FL_S,        16'd0,     1'b1);   // ack length wins over s
        send_fields(16'd20,    FL_S,        16'd0,     1'b1);   // start from peer
        send_fields(16'd20,    FL_L,        16'd10,    1'b0);   // single complete with l
        send_fields(16'd20,    FL_L,        16'd11,    1'b0);   // l total mismatch
        send_fields(16'd20,    8'h00,       16'hffff,  1'b0);   // plain complete
        send_fields(16'd20,    FL_M,        16'd0,     1'b0);   // m with no transfer
        send_fields(16'd20,    FL_L,        16'd16385, 1'b0);   // total above limit
        send_fields(16'd30,    FL_L | FL_M, 16'd5,     1'b0);   // fragment above total
        send_fields(16'd20,    FL_L | FL_M, 16'd30,    1'b0);   // first
        send_fields(16'd20,    FL_L | FL_M, 16'd30,    1'b0);   // l ignored mid transfer
        send_fields(16'd16,    8'h00,       16'd0,     1'b0);   // last, sums match
        send_fields(16'd15,    8'hdf & ~FL_S, 16'd100, 1'b1);   // first with reserved bits
        send_fields(16'hffff,  FL_M,        16'd0,     1'b0);   // overrun
        send_fields(16'hffff,  FL_M,        16'd0,     1'b0);
        send_fields(16'hffff,  FL_M,        16'd0,     1'b0);   // received count saturates
        send_fields(16'd7,     8'h00,       16'd0,     1'b0);   // last after overrun
        send_fields(16'd14,    FL_L | FL_M, 16'd8,     1'b0);   // first
        send_fields(16'd8,     8'h00,       16'd0,     1'b0);   // last, short by two
        send_fields(16'hffff,  8'hff,       16'hffff,  1'b1);   // all flags set
        send_fields(16'd6,     FL_L,        16'd0,     1'b1);   // ack length but l set
        send_fields(16'd10,    FL_L,        16'd0,     1'b1);   // empty record
        wait_drain();

        for (int p = 0; p < PHASES; p++) begin
            write_max(16'(phase_max[p]));
            target = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) send_record();
                else if (pick < 70) send_whole();
                else if (pick < 80) send_ack();
                else send_noise();
            end
            wait_drain();
        end

        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
